>>> src/pcir_pkg.sv
// shared constants, codes and types of the pair collision impulse resolver
`default_nettype none
package pcir_pkg;

    // fixed point format and field widths
    localparam int FRAC_BITS = 20;
    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int MD_W      = 25;
    localparam int GAIN_W    = 21;
    localparam int DIST_W    = MD_W;
    localparam int SUM_W     = 2 * MD_W;
    localparam int NM_W      = FRAC_BITS + 1;
    localparam int T_W       = DIFF_W;
    localparam int REL_W     = T_W + 3;
    localparam int R_W       = T_W + 2;
    localparam int PR_W      = R_W + GAIN_W;
    localparam int S_W       = R_W + 2;
    localparam int PP_W      = GAIN_W + MD_W;
    localparam int M_W       = S_W + 1;

    // configuration port
    localparam int IDX_W = 2;
    localparam int CFG_W = MD_W;
    localparam logic [IDX_W-1:0] REG_MIN_DIST    = 2'd0;
    localparam logic [IDX_W-1:0] REG_PUSH_GAIN   = 2'd1;
    localparam logic [IDX_W-1:0] REG_RESTITUTION = 2'd2;

    // reset values: 0.3, 0.2 and zero, rounded to nearest
    localparam logic [MD_W-1:0]   MIN_DIST_RST  = MD_W'(((3 * (1 << FRAC_BITS)) + 5) / 10);
    localparam logic [GAIN_W-1:0] PUSH_GAIN_RST = GAIN_W'(((2 * (1 << FRAC_BITS)) + 5) / 10);
    localparam logic [GAIN_W-1:0] RESTIT_RST    = '0;

    // pipeline depth: front end, square root, divide, back end
    localparam int FRONT_LAT = 4;
    localparam int BACK_LAT  = 6;
    localparam int PIPE_LAT  = FRONT_LAT + DIST_W + NM_W + BACK_LAT;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_IMPULSE = 2'd1,
        ACT_PUSH    = 2'd2
    } action_t;

    // data riding alongside the square root
    typedef struct packed {
        logic                        valid;
        logic                        contact;
        logic [2:0][MD_W-1:0]        dm;
        logic [2:0]                  dneg;
        logic [2:0][DIFF_W-1:0]      dvm;
        logic [2:0]                  dvneg;
    } sq_side_t;

    // data riding alongside the normal division
    typedef struct packed {
        logic                        valid;
        logic                        contact;
        logic [DIST_W-1:0]           root_len;
        logic [2:0]                  dneg;
        logic [2:0][DIFF_W-1:0]      dvm;
        logic [2:0]                  dvneg;
    } dv_side_t;

endpackage
`default_nettype wire

>>> src/pair_collision_impulse_resolver.sv
// top level of the pair collision impulse resolver pipeline
`default_nettype none
// Takes one body pair per clock (busy never rises) and returns one request of
// action and delta on done for each start that was taken, through these stages:
// four front-end stages (difference, magnitude, squares, sum and contact test),
// 25 square-root stages of one root bit each, 21 divide stages of one normal
// bit each, then six stages for relative speed, impulse or push and
// saturation. The result strobe cannot be held off by the receiver.
// Configuration registers may be written only when no request is in flight.
module pair_collision_impulse_resolver (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              cfg_we,
    input  wire logic [pcir_pkg::IDX_W-1:0]        cfg_index,
    input  wire logic [pcir_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic signed [pcir_pkg::COORD_W-1:0] pos_a_x,
    input  wire logic signed [pcir_pkg::COORD_W-1:0] pos_a_y,
    input  wire logic signed [pcir_pkg::COORD_W-1:0] pos_a_z,
    input  wire logic signed [pcir_pkg::COORD_W-1:0] pos_b_x,
    input  wire logic signed [pcir_pkg::COORD_W-1:0] pos_b_y,
    input  wire logic signed [pcir_pkg::COORD_W-1:0] pos_b_z,
    input  wire logic signed [pcir_pkg::COORD_W-1:0] vel_a_x,
    input  wire logic signed [pcir_pkg::COORD_W-1:0] vel_a_y,
    input  wire logic signed [pcir_pkg::COORD_W-1:0] vel_a_z,
    input  wire logic signed [pcir_pkg::COORD_W-1:0] vel_b_x,
    input  wire logic signed [pcir_pkg::COORD_W-1:0] vel_b_y,
    input  wire logic signed [pcir_pkg::COORD_W-1:0] vel_b_z,
    output logic                                   done,
    output logic [1:0]                             action,
    output logic signed [pcir_pkg::COORD_W-1:0]    delta_x,
    output logic signed [pcir_pkg::COORD_W-1:0]    delta_y,
    output logic signed [pcir_pkg::COORD_W-1:0]    delta_z
);
    import pcir_pkg::*;

    // configuration registers
    logic [MD_W-1:0]   min_dist_reg;
    logic [GAIN_W-1:0] push_gain_reg;
    logic [GAIN_W-1:0] restit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_dist_reg  <= MIN_DIST_RST;
            push_gain_reg <= PUSH_GAIN_RST;
            restit_reg    <= RESTIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_DIST:    min_dist_reg  <= cfg_data;
                REG_PUSH_GAIN:   push_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_RESTITUTION: restit_reg    <= cfg_data[GAIN_W-1:0];
                default:         ;
            endcase
        end
    end

    assign busy = 1'b0;

    // gather the axes
    logic signed [COORD_W-1:0] pa [3];
    logic signed [COORD_W-1:0] pb [3];
    logic signed [COORD_W-1:0] va [3];
    logic signed [COORD_W-1:0] vb [3];

    assign pa[0] = pos_a_x; assign pa[1] = pos_a_y; assign pa[2] = pos_a_z;
    assign pb[0] = pos_b_x; assign pb[1] = pos_b_y; assign pb[2] = pos_b_z;
    assign va[0] = vel_a_x; assign va[1] = vel_a_y; assign va[2] = vel_a_z;
    assign vb[0] = vel_b_x; assign vb[1] = vel_b_y; assign vb[2] = vel_b_z;

    // stage 1: position and velocity differences
    logic                     v1_reg;
    logic signed [DIFF_W-1:0] d_reg  [3];
    logic signed [DIFF_W-1:0] dv_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_reg[i]  <= DIFF_W'(pb[i]) - DIFF_W'(pa[i]);
            dv_reg[i] <= DIFF_W'(vb[i]) - DIFF_W'(va[i]);
        end
    end

    // stage 2: magnitudes and the per-axis distance test
    logic [DIFF_W-1:0] dm_full [3];
    logic [DIFF_W-1:0] dvm_full [3];
    logic              far_next;

    always_comb
    begin
        far_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            dm_full[i]  = d_reg[i][DIFF_W-1] ? DIFF_W'(-d_reg[i]) : DIFF_W'(d_reg[i]);
            dvm_full[i] = dv_reg[i][DIFF_W-1] ? DIFF_W'(-dv_reg[i]) : DIFF_W'(dv_reg[i]);
            if (dm_full[i] >= DIFF_W'(min_dist_reg))
                far_next = 1'b1;
        end
    end

    logic              v2_reg;
    logic              far2_reg;
    logic [MD_W-1:0]   dm2_reg   [3];
    logic [2:0]        dneg2_reg;
    logic [DIFF_W-1:0] dvm2_reg  [3];
    logic [2:0]        dvneg2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        far2_reg <= far_next;
        for (int i = 0; i < 3; i++)
        begin
            dm2_reg[i]    <= dm_full[i][MD_W-1:0];
            dneg2_reg[i]  <= d_reg[i][DIFF_W-1];
            dvm2_reg[i]   <= dvm_full[i];
            dvneg2_reg[i] <= dv_reg[i][DIFF_W-1];
        end
    end

    // stage 3: squares
    logic              v3_reg;
    logic              far3_reg;
    logic [SUM_W-1:0]  sq3_reg [3];
    logic [SUM_W-1:0]  mdsq3_reg;
    logic [MD_W-1:0]   dm3_reg   [3];
    logic [2:0]        dneg3_reg;
    logic [DIFF_W-1:0] dvm3_reg  [3];
    logic [2:0]        dvneg3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        far3_reg   <= far2_reg;
        mdsq3_reg  <= SUM_W'(min_dist_reg) * SUM_W'(min_dist_reg);
        dneg3_reg  <= dneg2_reg;
        dvneg3_reg <= dvneg2_reg;
        for (int i = 0; i < 3; i++)
        begin
            sq3_reg[i]  <= SUM_W'(dm2_reg[i]) * SUM_W'(dm2_reg[i]);
            dm3_reg[i]  <= dm2_reg[i];
            dvm3_reg[i] <= dvm2_reg[i];
        end
    end

    // stage 4: squared distance and contact test
    logic [SUM_W+1:0] sum_full;
    logic             contact_next;

    assign sum_full     = (SUM_W+2)'(sq3_reg[0]) + (SUM_W+2)'(sq3_reg[1])
                        + (SUM_W+2)'(sq3_reg[2]);
    assign contact_next = !far3_reg && (sum_full != '0)
                        && (sum_full < (SUM_W+2)'(mdsq3_reg));

    logic [SUM_W-1:0] sum4_reg;
    sq_side_t         side4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side4_reg <= '0;
        else
        begin
            side4_reg.valid   <= v3_reg;
            side4_reg.contact <= contact_next;
            side4_reg.dneg    <= dneg3_reg;
            side4_reg.dvneg   <= dvneg3_reg;
            for (int i = 0; i < 3; i++)
            begin
                side4_reg.dm[i]  <= dm3_reg[i];
                side4_reg.dvm[i] <= dvm3_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum4_reg <= sum_full[SUM_W-1:0];
    end

    // distance by square root, side data delayed alongside
    logic [DIST_W-1:0] root_len;
    sq_side_t          sq_line_reg [DIST_W];

    pcir_sqrt u_sqrt (
        .clk      (clk),
        .radicand (sum4_reg),
        .root     (root_len)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIST_W; k++)
                sq_line_reg[k] <= '0;
        end
        else
        begin
            sq_line_reg[0] <= side4_reg;
            for (int k = 1; k < DIST_W; k++)
                sq_line_reg[k] <= sq_line_reg[k-1];
        end
    end

    // unit normal magnitudes by division, side data delayed alongside
    sq_side_t        sq_out;
    dv_side_t        dv_in;
    dv_side_t        dv_line_reg [NM_W];
    logic [NM_W-1:0] nm [3];

    assign sq_out = sq_line_reg[DIST_W-1];

    always_comb
    begin
        dv_in.valid    = sq_out.valid;
        dv_in.contact  = sq_out.contact;
        dv_in.root_len = root_len;
        dv_in.dneg     = sq_out.dneg;
        dv_in.dvm      = sq_out.dvm;
        dv_in.dvneg    = sq_out.dvneg;
    end

    for (genvar i = 0; i < 3; i++) begin : g_div
        pcir_div u_div (
            .clk   (clk),
            .numer (sq_out.dm[i]),
            .denom (root_len),
            .quot  (nm[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NM_W; k++)
                dv_line_reg[k] <= '0;
        end
        else
        begin
            dv_line_reg[0] <= dv_in;
            for (int k = 1; k < NM_W; k++)
                dv_line_reg[k] <= dv_line_reg[k-1];
        end
    end

    dv_side_t dv_out;
    assign dv_out = dv_line_reg[NM_W-1];

    // back stage 1: relative speed terms
    logic              vr1_reg;
    logic              cr1_reg;
    logic [DIST_W-1:0] dist_r1_reg;
    logic [T_W-1:0]    t_r1_reg  [3];
    logic [2:0]        tneg_r1_reg;
    logic [NM_W-1:0]   nm_r1_reg [3];
    logic [2:0]        dneg_r1_reg;
    logic [T_W+NM_W-1:0] tprod [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            tprod[i] = (T_W+NM_W)'(dv_out.dvm[i]) * (T_W+NM_W)'(nm[i]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vr1_reg <= 1'b0;
        else
            vr1_reg <= dv_out.valid;
    end

    always_ff @(posedge clk)
    begin
        cr1_reg     <= dv_out.contact;
        dist_r1_reg <= dv_out.root_len;
        dneg_r1_reg <= dv_out.dneg;
        for (int i = 0; i < 3; i++)
        begin
            t_r1_reg[i]    <= tprod[i][T_W+FRAC_BITS-1:FRAC_BITS];
            tneg_r1_reg[i] <= dv_out.dvneg[i] != dv_out.dneg[i];
            nm_r1_reg[i]   <= nm[i];
        end
    end

    // back stage 2: relative speed sum and push amount
    logic signed [REL_W-1:0] rel_next;
    logic [PP_W-1:0]         pp_prod;

    always_comb
    begin
        rel_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (tneg_r1_reg[i])
                rel_next = rel_next - $signed(REL_W'(t_r1_reg[i]));
            else
                rel_next = rel_next + $signed(REL_W'(t_r1_reg[i]));
        end
    end

    assign pp_prod = PP_W'(push_gain_reg) * PP_W'(min_dist_reg - dist_r1_reg);

    logic                    vr2_reg;
    logic                    cr2_reg;
    logic signed [REL_W-1:0] rel_r2_reg;
    logic [S_W-1:0]          pp_r2_reg;
    logic [NM_W-1:0]         nm_r2_reg [3];
    logic [2:0]              dneg_r2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vr2_reg <= 1'b0;
        else
            vr2_reg <= vr1_reg;
    end

    always_ff @(posedge clk)
    begin
        cr2_reg     <= cr1_reg;
        rel_r2_reg  <= rel_next;
        pp_r2_reg   <= S_W'(pp_prod[PP_W-1:FRAC_BITS]);
        dneg_r2_reg <= dneg_r1_reg;
        for (int i = 0; i < 3; i++)
            nm_r2_reg[i] <= nm_r1_reg[i];
    end

    // back stage 3: approach speed times restitution
    logic [REL_W-1:0] rel_neg;
    logic [R_W-1:0]   r_mag;
    logic [PR_W-1:0]  rprod;

    assign rel_neg = REL_W'(-rel_r2_reg);
    assign r_mag   = rel_neg[R_W-1:0];
    assign rprod   = PR_W'(r_mag) * PR_W'(restit_reg);

    logic              vr3_reg;
    logic              cr3_reg;
    logic              imp_r3_reg;
    logic [R_W-1:0]    r_r3_reg;
    logic [S_W-1:0]    rp_r3_reg;
    logic [S_W-1:0]    pp_r3_reg;
    logic [NM_W-1:0]   nm_r3_reg [3];
    logic [2:0]        dneg_r3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vr3_reg <= 1'b0;
        else
            vr3_reg <= vr2_reg;
    end

    always_ff @(posedge clk)
    begin
        cr3_reg     <= cr2_reg;
        imp_r3_reg  <= rel_r2_reg < 0;
        r_r3_reg    <= r_mag;
        rp_r3_reg   <= S_W'(rprod[PR_W-1:FRAC_BITS]);
        pp_r3_reg   <= pp_r2_reg;
        dneg_r3_reg <= dneg_r2_reg;
        for (int i = 0; i < 3; i++)
            nm_r3_reg[i] <= nm_r2_reg[i];
    end

    // back stage 4: scalar size of the delta and the action code
    logic              vr4_reg;
    action_t           act_r4_reg;
    logic [S_W-1:0]    s_r4_reg;
    logic [NM_W-1:0]   nm_r4_reg [3];
    logic [2:0]        dneg_r4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vr4_reg <= 1'b0;
        else
            vr4_reg <= vr3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (!cr3_reg)
            act_r4_reg <= ACT_NONE;
        else if (imp_r3_reg)
            act_r4_reg <= ACT_IMPULSE;
        else
            act_r4_reg <= ACT_PUSH;
        s_r4_reg    <= imp_r3_reg ? S_W'(r_r3_reg) + rp_r3_reg : pp_r3_reg;
        dneg_r4_reg <= dneg_r3_reg;
        for (int i = 0; i < 3; i++)
            nm_r4_reg[i] <= nm_r3_reg[i];
    end

    // back stage 5: scale the normal
    logic [S_W+NM_W-1:0] mprod [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            mprod[i] = (S_W+NM_W)'(s_r4_reg) * (S_W+NM_W)'(nm_r4_reg[i]);
    end

    logic              vr5_reg;
    action_t           act_r5_reg;
    logic [M_W-1:0]    m_r5_reg [3];
    logic [2:0]        dneg_r5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vr5_reg <= 1'b0;
        else
            vr5_reg <= vr4_reg;
    end

    always_ff @(posedge clk)
    begin
        act_r5_reg  <= act_r4_reg;
        dneg_r5_reg <= dneg_r4_reg;
        for (int i = 0; i < 3; i++)
            m_r5_reg[i] <= M_W'(mprod[i][S_W+NM_W-1:FRAC_BITS]);
    end

    // back stage 6: sign, saturation and the result register
    logic [COORD_W-1:0] sat [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (act_r5_reg == ACT_NONE)
                sat[i] = '0;
            else if (dneg_r5_reg[i])
            begin
                if (m_r5_reg[i] >= (M_W'(1) << (COORD_W - 1)))
                    sat[i] = {1'b1, {(COORD_W-1){1'b0}}};
                else
                    sat[i] = -m_r5_reg[i][COORD_W-1:0];
            end
            else
            begin
                if (m_r5_reg[i] >= (M_W'(1) << (COORD_W - 1)))
                    sat[i] = {1'b0, {(COORD_W-1){1'b1}}};
                else
                    sat[i] = m_r5_reg[i][COORD_W-1:0];
            end
        end
    end

    logic               done_reg;
    action_t            action_reg;
    logic [COORD_W-1:0] dx_reg;
    logic [COORD_W-1:0] dy_reg;
    logic [COORD_W-1:0] dz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vr5_reg;
    end

    always_ff @(posedge clk)
    begin
        action_reg <= act_r5_reg;
        dx_reg     <= sat[0];
        dy_reg     <= sat[1];
        dz_reg     <= sat[2];
    end

    assign done    = done_reg;
    assign action  = action_reg;
    assign delta_x = $signed(dx_reg);
    assign delta_y = $signed(dy_reg);
    assign delta_z = $signed(dz_reg);

    // a taken request comes out after the fixed pipeline depth
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##PIPE_LAT done)
        else $error("request lost in the pipeline");

    // nothing comes out that was not taken
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##PIPE_LAT !done)
        else $error("result without a request");

    // no contact gives zero deltas
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && action == ACT_NONE) |-> (delta_x == 0 && delta_y == 0 && delta_z == 0))
        else $error("nonzero delta without contact");

endmodule
`default_nettype wire

>>> src/pcir_sqrt.sv
// pipelined integer square root, one result bit per stage
`default_nettype none
module pcir_sqrt (
    input  wire logic                          clk,
    input  wire logic [pcir_pkg::SUM_W-1:0]    radicand,
    output logic      [pcir_pkg::DIST_W-1:0]   root
);
    import pcir_pkg::*;

    localparam int TW = SUM_W + 2;

    logic [TW-1:0]     rem_d    [DIST_W];
    logic [DIST_W-1:0] root_d   [DIST_W];
    logic [TW-1:0]     rem_reg  [DIST_W];
    logic [DIST_W-1:0] root_reg [DIST_W];

    assign rem_d[0]  = TW'(radicand);
    assign root_d[0] = '0;

    for (genvar k = 0; k < DIST_W; k++) begin : g_stage
        localparam int B = DIST_W - 1 - k;
        logic [TW-1:0] trial;

        if (k > 0) begin : g_link
            assign rem_d[k]  = rem_reg[k-1];
            assign root_d[k] = root_reg[k-1];
        end

        // (root + 2^b)^2 - root^2
        assign trial = (TW'(root_d[k]) << (B + 1)) + (TW'(1) << (2 * B));

        always_ff @(posedge clk)
        begin
            if (rem_d[k] >= trial)
            begin
                rem_reg[k]  <= rem_d[k] - trial;
                root_reg[k] <= root_d[k] | (DIST_W'(1) << B);
            end
            else
            begin
                rem_reg[k]  <= rem_d[k];
                root_reg[k] <= root_d[k];
            end
        end
    end

    assign root = root_reg[DIST_W-1];

endmodule
`default_nettype wire

>>> src/pcir_div.sv
// pipelined restoring divider for one normal component, one quotient bit per stage
`default_nettype none
module pcir_div (
    input  wire logic                          clk,
    input  wire logic [pcir_pkg::MD_W-1:0]     numer,
    input  wire logic [pcir_pkg::DIST_W-1:0]   denom,
    output logic      [pcir_pkg::NM_W-1:0]     quot
);
    import pcir_pkg::*;

    localparam int RW = MD_W + FRAC_BITS + 1;

    logic [RW-1:0]     rem_d    [NM_W];
    logic [NM_W-1:0]   quot_d   [NM_W];
    logic [DIST_W-1:0] den_d    [NM_W];
    logic [RW-1:0]     rem_reg  [NM_W];
    logic [NM_W-1:0]   quot_reg [NM_W];
    logic [DIST_W-1:0] den_reg  [NM_W];

    // numerator scaled by one in fixed point
    assign rem_d[0]  = RW'(numer) << FRAC_BITS;
    assign quot_d[0] = '0;
    assign den_d[0]  = denom;

    for (genvar k = 0; k < NM_W; k++) begin : g_stage
        localparam int B = NM_W - 1 - k;
        logic [RW-1:0] trial;

        if (k > 0) begin : g_link
            assign rem_d[k]  = rem_reg[k-1];
            assign quot_d[k] = quot_reg[k-1];
            assign den_d[k]  = den_reg[k-1];
        end

        assign trial = RW'(den_d[k]) << B;

        always_ff @(posedge clk)
        begin
            den_reg[k] <= den_d[k];
            if (rem_d[k] >= trial)
            begin
                rem_reg[k]  <= rem_d[k] - trial;
                quot_reg[k] <= quot_d[k] | (NM_W'(1) << B);
            end
            else
            begin
                rem_reg[k]  <= rem_d[k];
                quot_reg[k] <= quot_d[k];
            end
        end
    end

    assign quot = quot_reg[NM_W-1];

endmodule
`default_nettype wire
